// ===== rtl/star_pkg.sv =====
// ----------------------------------------------------------------------------
// star_pkg: shared constants for the sensor table running average
// Operation and status codes, threshold reset values, config register addresses.
// ----------------------------------------------------------------------------
`default_nettype none
package star_pkg;
  localparam int TableEntriesDef = 16;
  localparam int WindowLengthDef = 5;

  localparam logic [1:0] OP_MAP    = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_DUP     = 2'd3;

  localparam logic [15:0] MinTempReset = 16'sd0;
  localparam logic [15:0] MaxTempReset = 16'sd7680;

  localparam int CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_MIN = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_MAX = 3'd4;
endpackage
`default_nettype wire

// ===== rtl/star_stream_if.sv =====
// ----------------------------------------------------------------------------
// star_stream_if: valid/ready channel carrying a payload of type T
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface star_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/star_ram.sv =====
// ----------------------------------------------------------------------------
// star_ram: generic single-port-write, single-read RAM, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module star_ram #(
  parameter int Width = 16,
  parameter int Depth = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/star_front.sv =====
// ----------------------------------------------------------------------------
// star_front: command intake
// Accepts input transactions and queues them in a two-entry FIFO for the back.
// ----------------------------------------------------------------------------
`default_nettype none
module star_front #(
  parameter type T = logic
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire T     in_data,
  output logic      q_valid,
  input  wire logic q_pop,
  output T          q_data
);
  T            slot_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (q_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/star_back.sv =====
// ----------------------------------------------------------------------------
// star_back: table search, window update and result build
// Scans entries one per cycle, walks the window through the sample RAM,
// divides the sum by the window length with a reciprocal and drives a result.
// ----------------------------------------------------------------------------
`default_nettype none
module star_back #(
  parameter int TableEntries = 16,
  parameter int WindowLength = 5,
  parameter type CmdT = logic,
  parameter type ResT = logic
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire CmdT         cmd,
  input  wire logic [15:0] min_temp,
  input  wire logic [15:0] max_temp,
  output logic             res_valid,
  input  wire logic        res_ready,
  output ResT              res_data
);
  import star_pkg::*;

  localparam int IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW  = $clog2(TableEntries + 1);
  localparam int WinW  = $clog2(WindowLength + 1);
  localparam int SlotW = (WindowLength > 1) ? $clog2(WindowLength) : 1;
  localparam int RamD  = TableEntries * WindowLength;
  localparam int RamAW = $clog2(RamD) > 0 ? $clog2(RamD) : 1;
  localparam int SumW  = 21;
  localparam int RecSh = 24;
  localparam logic [24:0] Recip = 25'((64'd1 << RecSh) / WindowLength + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DEC = 4'd2, S_CLR = 4'd3,
                         S_RD = 4'd4, S_ACC = 4'd5, S_MUL = 4'd6, S_FIX = 4'd7,
                         S_OUT = 4'd8;

  logic [3:0]       st_r, st_nxt;
  logic             valid_r [TableEntries];
  logic [15:0]      sens_r  [TableEntries];
  logic [15:0]      room_r  [TableEntries];
  logic [15:0]      avg_r   [TableEntries];
  logic [31:0]      time_r  [TableEntries];
  logic [WinW-1:0]  fill_r  [TableEntries];
  logic [CntW-1:0]  used_r;
  logic [CntW-1:0]  scan_r;
  logic             hit_r, free_r;
  logic [IdxW-1:0]  hit_idx_r, free_idx_r, idx_r;
  logic [SlotW-1:0] k_r;
  logic             rd_pend_r;
  logic signed [SumW-1:0] sum_r;
  logic [45:0]      prod_r;
  logic [1:0]       stat_r;
  logic             addressed_r;
  logic             out_r;
  ResT              res_r;

  logic             we;
  logic [RamAW-1:0] waddr, raddr;
  logic [15:0]      wdata, rdata;
  logic [IdxW-1:0]  sidx;
  logic [RamAW-1:0] base;
  logic [SumW-1:0]  mag;
  logic [15:0]      quo;
  logic [15:0]      oavg;
  logic             ofull;

  star_ram #(.Width(16), .Depth(RamD)) u_win (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign sidx = scan_r[IdxW-1:0];
  assign base = RamAW'(idx_r) * RamAW'(WindowLength);
  assign raddr = base + RamAW'(k_r) + ((st_r == S_RD && WindowLength > 1) ? RamAW'(1) : '0);
  assign mag  = sum_r[SumW-1] ? SumW'(-sum_r) : SumW'(sum_r);

  always_comb begin
    we = 1'b0; waddr = base + RamAW'(k_r); wdata = '0;
    if (st_r == S_CLR) begin
      we = 1'b1;
    end else if (st_r == S_ACC && rd_pend_r) begin
      we = 1'b1; wdata = rdata;
    end else if (st_r == S_ACC && !rd_pend_r) begin
      we = 1'b1; wdata = cmd.sample_value;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid && !out_r) st_nxt = S_SCAN;
      S_SCAN: if (scan_r == CntW'(TableEntries - 1)) st_nxt = S_DEC;
      S_DEC: begin
        if (cmd.op == OP_MAP && !hit_r && free_r) st_nxt = S_CLR;
        else if (cmd.op == OP_SAMPLE && hit_r) st_nxt = (WindowLength > 1) ? S_RD : S_ACC;
        else st_nxt = S_OUT;
      end
      S_CLR:  if (k_r == SlotW'(WindowLength - 1)) st_nxt = S_OUT;
      S_RD:   st_nxt = S_ACC;
      S_ACC:  st_nxt = rd_pend_r ? S_RD : S_MUL;
      S_MUL:  st_nxt = S_FIX;
      S_FIX:  st_nxt = S_OUT;
      S_OUT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign quo = prod_r[RecSh +: 16];

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        scan_r <= '0; hit_r <= 1'b0; free_r <= 1'b0;
      end
      S_SCAN: begin
        scan_r <= scan_r + 1'b1;
        if (valid_r[sidx] && sens_r[sidx] == cmd.sensor_number && !hit_r) begin
          hit_r <= 1'b1; hit_idx_r <= sidx;
        end
        if (!valid_r[sidx] && !free_r) begin
          free_r <= 1'b1; free_idx_r <= sidx;
        end
      end
      S_DEC: begin
        k_r <= '0; sum_r <= '0; rd_pend_r <= (WindowLength > 1);
        if (cmd.op == OP_MAP && !hit_r && free_r) begin
          stat_r <= ST_OK; idx_r <= free_idx_r; addressed_r <= 1'b1;
          room_r[free_idx_r] <= cmd.room_number;
          sens_r[free_idx_r] <= cmd.sensor_number;
          avg_r[free_idx_r]  <= '0;
          time_r[free_idx_r] <= '0;
        end else begin
          idx_r <= hit_idx_r; addressed_r <= hit_r;
          if (cmd.op == OP_MAP) stat_r <= hit_r ? ST_DUP : ST_FULL;
          else stat_r <= hit_r ? ST_OK : ST_UNKNOWN;
        end
      end
      S_CLR: k_r <= k_r + 1'b1;
      S_ACC: begin
        if (rd_pend_r) begin
          sum_r <= sum_r + SumW'(signed'(rdata));
          k_r   <= k_r + 1'b1;
          rd_pend_r <= (k_r != SlotW'(WindowLength - 2));
        end else begin
          sum_r <= sum_r + SumW'(signed'(cmd.sample_value));
        end
      end
      S_MUL: prod_r <= 46'(mag) * 46'(Recip);
      S_FIX: begin
        avg_r[idx_r]  <= sum_r[SumW-1] ? 16'(-quo) : quo;
        time_r[idx_r] <= cmd.time_stamp;
      end
      default: ;
    endcase
  end

  // Mark the entry taken or advance its fill count once the scan has decided.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; used_r <= '0; out_r <= 1'b0;
      for (int i = 0; i < TableEntries; i++) begin
        valid_r[i] <= 1'b0; fill_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DEC) begin
        if (cmd.op == OP_MAP && !hit_r && free_r) begin
          valid_r[free_idx_r] <= 1'b1; fill_r[free_idx_r] <= '0;
          used_r <= used_r + 1'b1;
        end else if (cmd.op == OP_SAMPLE && hit_r) begin
          if (fill_r[hit_idx_r] != WinW'(WindowLength))
            fill_r[hit_idx_r] <= fill_r[hit_idx_r] + 1'b1;
        end
      end
      if (st_r == S_OUT) out_r <= 1'b1;
      else if (res_ready) out_r <= 1'b0;
    end
  end

  assign oavg  = avg_r[idx_r];
  assign ofull = fill_r[idx_r] == WinW'(WindowLength);

  always_ff @(posedge clk) begin
    if (st_r == S_OUT) begin
      res_r.status       <= stat_r;
      res_r.sensor_count <= 5'(used_r);
      res_r.room_out     <= addressed_r ? room_r[idx_r] : '0;
      res_r.average_out  <= addressed_r ? oavg : '0;
      res_r.last_time    <= addressed_r ? time_r[idx_r] : '0;
      res_r.too_cold     <= addressed_r && ofull && $signed(oavg) < $signed(min_temp);
      res_r.too_hot      <= addressed_r && ofull && !($signed(oavg) < $signed(min_temp))
                            && $signed(oavg) > $signed(max_temp);
    end
  end

  assign q_pop     = (st_r == S_OUT);
  assign res_valid = out_r;
  assign res_data  = res_r;
endmodule
`default_nettype wire

// ===== rtl/sensor_table_running_average.sv =====
// ----------------------------------------------------------------------------
// sensor_table_running_average: per-sensor moving average with alarms
//
//  channel | dir | handshake          | payload
//  in_     | in  | valid/ready        | op, sensor, room, sample, time stamp
//  out_    | out | valid/ready        | status, room, average, time, alarms, count
//  cfg_    | in  | APB, pready high   | min/max thresholds at 0x0 / 0x4
//
// A transaction holds the back end through the one-entry-a-cycle table scan and,
// on a new map or a sample, through the window walk on the single RAM port.
// Reset is synchronous; the window RAM needs no clearing since a new entry is
// zeroed on mapping. A waiting result holds the back end; the intake FIFO still
// takes two transactions.
// ----------------------------------------------------------------------------
`default_nettype none
module sensor_table_running_average #(
  parameter int TableEntries = star_pkg::TableEntriesDef,
  parameter int WindowLength = star_pkg::WindowLengthDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  star_stream_if.sink   in_,
  star_stream_if.source out_,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [star_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import star_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] sensor_number;
    logic [15:0] room_number;
    logic [15:0] sample_value;
    logic [31:0] time_stamp;
  } cmd_t;
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] room_out;
    logic [15:0] average_out;
    logic [31:0] last_time;
    logic        too_cold;
    logic        too_hot;
    logic [4:0]  sensor_count;
  } res_t;

  logic [15:0] min_r, max_r;
  logic        q_valid, q_pop;
  cmd_t        q_data, in_cmd;
  res_t        res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_MAX) ? {{16{max_r[15]}}, max_r}
                    : (cfg_paddr == REG_MIN) ? {{16{min_r[15]}}, min_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MinTempReset; max_r <= MaxTempReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == REG_MIN) min_r <= cfg_pwdata[15:0];
      if (cfg_paddr == REG_MAX) max_r <= cfg_pwdata[15:0];
    end
  end

  assign in_cmd = '{op: in_.data.op, sensor_number: in_.data.sensor_number,
                    room_number: in_.data.room_number,
                    sample_value: in_.data.sample_value, time_stamp: in_.data.time_stamp};

  star_front #(.T(cmd_t)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_.valid), .in_ready(in_.ready),
    .in_data(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  star_back #(.TableEntries(TableEntries), .WindowLength(WindowLength),
              .CmdT(cmd_t), .ResT(res_t)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .cmd(q_data),
    .min_temp(min_r), .max_temp(max_r), .res_valid(out_.valid),
    .res_ready(out_.ready), .res_data(res)
  );

  assign out_.data.status       = res.status;
  assign out_.data.room_out     = res.room_out;
  assign out_.data.average_out  = res.average_out;
  assign out_.data.last_time    = res.last_time;
  assign out_.data.too_cold     = res.too_cold;
  assign out_.data.too_hot      = res.too_hot;
  assign out_.data.sensor_count = res.sensor_count;
endmodule
`default_nettype wire

// ===== rtl/star_checker.sv =====
// ----------------------------------------------------------------------------
// star_checker: port-level checks on the sensor table
// ----------------------------------------------------------------------------
`default_nettype none
module star_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic        out_too_cold,
  input wire logic        out_too_hot,
  input wire logic [15:0] out_room,
  input wire logic        cfg_pready
);
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_too_cold && out_too_hot)) else $error("both alarms");
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 2'd1 || out_status == 2'd2) |-> out_room == 16'd0
    && !out_too_cold && !out_too_hot) else $error("failed item carries fields");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)) else $error("dropped");
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
endmodule

bind sensor_table_running_average star_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_.valid), .out_ready(out_.ready),
  .out_status(out_.data.status), .out_too_cold(out_.data.too_cold),
  .out_too_hot(out_.data.too_hot), .out_room(out_.data.room_out),
  .cfg_pready(cfg_pready)
);
`default_nettype wire
